// ===== design/tcpf_pkg.sv =====
// shared types, register codes and reset values for the tabletop cylinder point filter
package tcpf_pkg;

    localparam int TCPF_INDEX_BITS = 19;
    localparam int TCPF_COORD_W    = 32;
    localparam int TCPF_NORMAL_W   = 18;
    localparam int TCPF_RADIUS_W   = 31;
    localparam int TCPF_CFG_IDX_W  = 8;
    localparam int TCPF_CFG_DATA_W = 32;

    typedef enum logic [TCPF_CFG_IDX_W-1:0] {
        REG_NORMAL_X      = 8'd0,
        REG_NORMAL_Y      = 8'd1,
        REG_NORMAL_Z      = 8'd2,
        REG_CENTER_X      = 8'd3,
        REG_CENTER_Y      = 8'd4,
        REG_CENTER_Z      = 8'd5,
        REG_KEEP_RADIUS   = 8'd6,
        REG_HEIGHT_MARGIN = 8'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [TCPF_NORMAL_W-1:0] normal_x;
        logic signed [TCPF_NORMAL_W-1:0] normal_y;
        logic signed [TCPF_NORMAL_W-1:0] normal_z;
        logic signed [TCPF_COORD_W-1:0]  center_x;
        logic signed [TCPF_COORD_W-1:0]  center_y;
        logic signed [TCPF_COORD_W-1:0]  center_z;
        logic        [TCPF_RADIUS_W-1:0] keep_radius;
        logic signed [TCPF_COORD_W-1:0]  height_margin;
    } t_cfg;

    localparam logic signed [TCPF_NORMAL_W-1:0] RST_NORMAL_X      = 18'sd0;
    localparam logic signed [TCPF_NORMAL_W-1:0] RST_NORMAL_Y      = 18'sd0;
    localparam logic signed [TCPF_NORMAL_W-1:0] RST_NORMAL_Z      = 18'sd65536;
    localparam logic signed [TCPF_COORD_W-1:0]  RST_CENTER        = 32'sd0;
    localparam logic        [TCPF_RADIUS_W-1:0] RST_KEEP_RADIUS   = 31'd32768;
    localparam logic signed [TCPF_COORD_W-1:0]  RST_HEIGHT_MARGIN = -32'sd655;

endpackage

// ===== design/tcpf_cfg.sv =====
// configuration register bank of the tabletop cylinder point filter
module tcpf_cfg
    import tcpf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [TCPF_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TCPF_CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NORMAL_X:      n_cfg.normal_x      = i_cfg_data[TCPF_NORMAL_W-1:0];
                REG_NORMAL_Y:      n_cfg.normal_y      = i_cfg_data[TCPF_NORMAL_W-1:0];
                REG_NORMAL_Z:      n_cfg.normal_z      = i_cfg_data[TCPF_NORMAL_W-1:0];
                REG_CENTER_X:      n_cfg.center_x      = i_cfg_data[TCPF_COORD_W-1:0];
                REG_CENTER_Y:      n_cfg.center_y      = i_cfg_data[TCPF_COORD_W-1:0];
                REG_CENTER_Z:      n_cfg.center_z      = i_cfg_data[TCPF_COORD_W-1:0];
                REG_KEEP_RADIUS:   n_cfg.keep_radius   = i_cfg_data[TCPF_RADIUS_W-1:0];
                REG_HEIGHT_MARGIN: n_cfg.height_margin = i_cfg_data[TCPF_COORD_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x      <= RST_NORMAL_X;
            r_cfg.normal_y      <= RST_NORMAL_Y;
            r_cfg.normal_z      <= RST_NORMAL_Z;
            r_cfg.center_x      <= RST_CENTER;
            r_cfg.center_y      <= RST_CENTER;
            r_cfg.center_z      <= RST_CENTER;
            r_cfg.keep_radius   <= RST_KEEP_RADIUS;
            r_cfg.height_margin <= RST_HEIGHT_MARGIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/tabletop_cylinder_point_filter_unit.sv =====
// top level: pipelined cylinder region test of streamed 3d points
//
// One point enters and one result leaves per clock while the output is not stalled; each point
// passes through the nine-stage datapath to the output register: offset from the centre,
// three products with the normal, their sum, rounding and the height test, three products
// of the rounded height with the normal, the horizontal offset, its magnitude, the squares,
// and the final sum and radius compare.
// Every stage has its own valid bit and moves on when the stage after it is empty or
// moving, so a stalled output holds its result while earlier stages keep filling gaps.
// Configuration writes are taken in any cycle and are meant to be made while no point is
// in flight.
module tabletop_cylinder_point_filter_unit
    import tcpf_pkg::*;
#(
    parameter  int INDEX_BITS = TCPF_INDEX_BITS,
    localparam int S_DATA_W   = ((3 * TCPF_COORD_W + INDEX_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((INDEX_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [TCPF_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TCPF_CFG_DATA_W-1:0] i_cfg_data,
    // point input
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [S_DATA_W-1:0]        i_s_tdata,  // point_x, point_y, point_z, point_index
    input  logic [0:0]                 i_s_tuser,  // point_invalid
    // result output
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [M_DATA_W-1:0]        o_m_tdata,  // kept_index
    output logic [0:0]                 o_m_tuser   // inside_res
);

    localparam int NST  = 9;
    localparam int DW   = TCPF_COORD_W + 1;
    localparam int P1W  = DW + TCPF_NORMAL_W;
    localparam int HW   = P1W + 2;
    localparam int HRW  = HW + 1;
    localparam int H16W = HRW - 16;
    localparam int P2W  = H16W + TCPF_NORMAL_W;
    localparam int QW   = P2W + 2;
    localparam int EW   = QW - 16;
    localparam int AW   = TCPF_COORD_W - 1;
    localparam int SQW  = 2 * AW;
    localparam int SUMW = SQW + 2;

    t_cfg w_cfg;

    tcpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    logic signed [TCPF_NORMAL_W-1:0] w_n [3];
    logic signed [TCPF_COORD_W-1:0]  w_c [3];
    logic signed [TCPF_COORD_W-1:0]  w_p [3];

    assign w_n[0] = w_cfg.normal_x;
    assign w_n[1] = w_cfg.normal_y;
    assign w_n[2] = w_cfg.normal_z;
    assign w_c[0] = w_cfg.center_x;
    assign w_c[1] = w_cfg.center_y;
    assign w_c[2] = w_cfg.center_z;
    assign w_p[0] = i_s_tdata[TCPF_COORD_W-1:0];
    assign w_p[1] = i_s_tdata[2*TCPF_COORD_W-1:TCPF_COORD_W];
    assign w_p[2] = i_s_tdata[3*TCPF_COORD_W-1:2*TCPF_COORD_W];

    // stage handshake
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_tready = w_en[0];
    assign o_m_tvalid = r_vld[NST-1];

    // payload carried along the pipe
    logic [INDEX_BITS-1:0] r_idx [NST];
    logic                  r_inv [3];
    logic signed [DW-1:0]  r_d [5][3];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_idx[0] <= i_s_tdata[3*TCPF_COORD_W+INDEX_BITS-1:3*TCPF_COORD_W];
            r_inv[0] <= i_s_tuser[0];
            for (int i = 0; i < 3; i++) begin
                r_d[0][i] <= DW'(w_p[i]) - DW'(w_c[i]);
            end
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
        for (int k = 1; k < 3; k++) begin
            if (w_en[k]) begin
                r_inv[k] <= r_inv[k-1];
            end
        end
        for (int k = 1; k < 5; k++) begin
            if (w_en[k]) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    // height along the normal
    logic signed [P1W-1:0] r_p1 [3];
    logic signed [HW-1:0]  r_h;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= r_d[0][i] * w_n[i];
            end
        end
        if (w_en[2]) begin
            r_h <= HW'(r_p1[0]) + HW'(r_p1[1]) + HW'(r_p1[2]);
        end
    end

    // rounding to q16.16 and height test
    logic signed [HRW-1:0]  w_hr;
    logic signed [HRW-1:0]  w_thr;
    logic signed [H16W-1:0] r_h16;
    logic                   r_ok3;

    assign w_hr  = HRW'(r_h) + HRW'(32768);
    assign w_thr = (-HRW'(w_cfg.height_margin)) <<< 16;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_h16 <= w_hr[HRW-1:16];
            r_ok3 <= !r_inv[2] && (HRW'(r_h) > w_thr);
        end
    end

    // horizontal offset
    logic signed [P2W-1:0] r_p2 [3];
    logic                  r_ok4;
    logic signed [QW-1:0]  r_q [3];
    logic                  r_ok5;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_p2[i] <= r_h16 * w_n[i];
            end
            r_ok4 <= r_ok3;
        end
        if (w_en[5]) begin
            for (int i = 0; i < 3; i++) begin
                // d - round(p) folded into one floor of a single sum
                r_q[i] <= (QW'(r_d[4][i]) <<< 16) - QW'(r_p2[i]) + QW'(32767);
            end
            r_ok5 <= r_ok4;
        end
    end

    // magnitude and range check
    logic signed [EW-1:0] w_e [3];
    logic        [EW-1:0] w_a [3];
    logic        [2:0]    w_big;
    logic        [AW-1:0] r_a [3];
    logic                 r_ok6;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e[i]   = r_q[i][QW-1:16];
            w_a[i]   = w_e[i][EW-1] ? EW'(-w_e[i]) : EW'(w_e[i]);
            w_big[i] = |w_a[i][EW-1:AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= w_a[i][AW-1:0];
            end
            r_ok6 <= r_ok5 && !(|w_big);
        end
    end

    // squares and radius compare
    logic [SQW-1:0] r_sq [3];
    logic [SQW-1:0] r_rr;
    logic           r_ok7;
    logic [SUMW-1:0] w_sum;
    logic           r_in;

    assign w_sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_a[i] * r_a[i];
            end
            r_rr  <= w_cfg.keep_radius * w_cfg.keep_radius;
            r_ok7 <= r_ok6;
        end
        if (w_en[8]) begin
            r_in <= r_ok7 && (w_sum < SUMW'(r_rr));
        end
    end

    assign o_m_tdata    = M_DATA_W'(r_idx[NST-1]);
    assign o_m_tuser[0] = r_in;

    // checks
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_cfg.keep_radius == '0) |-> !o_m_tuser[0])
        else $error("point kept with zero radius");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NST-1] |-> o_s_tready)
        else $error("input stalled with empty output stage");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_en[1]) |=> r_vld[1])
        else $error("request lost between first stages");

    a_range_rejects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && w_en[6] && (|w_big)) |=> !r_ok6)
        else $error("large horizontal offset not rejected");

endmodule

// ===== verif/tabletop_cylinder_point_filter_unit_test.sv =====
// self-checking stream testbench for the tabletop cylinder point filter
`timescale 1ns / 1ps

module tabletop_cylinder_point_filter_unit_test;
    import tcpf_pkg::*;

    localparam int PT_W      = ((3 * TCPF_COORD_W + TCPF_INDEX_BITS + 7) / 8) * 8;
    localparam int RES_W     = ((TCPF_INDEX_BITS + 7) / 8) * 8;
    localparam int QUIET_MAX = 3000;
    localparam int HOLD_AT   = 400;
    localparam int HOLD_LEN  = 300;
    localparam int PRINT_MAX = 200;

    typedef struct {
        logic signed [TCPF_COORD_W-1:0]    x;
        logic signed [TCPF_COORD_W-1:0]    y;
        logic signed [TCPF_COORD_W-1:0]    z;
        logic                              invalid;
        logic        [TCPF_INDEX_BITS-1:0] index;
    } t_point;

    typedef struct {
        logic [TCPF_INDEX_BITS-1:0] index;
        logic                       keep;
    } t_verdict;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [TCPF_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TCPF_CFG_DATA_W-1:0] cfg_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [PT_W-1:0]            s_tdata = '0;
    logic [0:0]                 s_tuser = '0;
    logic                       o_m_tvalid;
    logic                       m_tready = 1'b0;
    logic [RES_W-1:0]           o_m_tdata;
    logic [0:0]                 o_m_tuser;

    t_cfg     filt_cfg;
    t_point   point_q[$];
    t_verdict verdict_q[$];
    int       errors = 0;
    int       results_seen = 0;
    bit       no_idle = 1'b0;

    always #1 i_clk = ~i_clk;

    tabletop_cylinder_point_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    function automatic logic cylinder_hit(input t_cfg c, input t_point p);
        longint          n[3];
        longint          d[3];
        longint          h;
        longint          h16;
        longint          e;
        longint          a;
        longint unsigned sq_sum;
        longint unsigned r;
        logic            ok;
        n[0] = longint'(c.normal_x);
        n[1] = longint'(c.normal_y);
        n[2] = longint'(c.normal_z);
        d[0] = longint'(p.x) - longint'(c.center_x);
        d[1] = longint'(p.y) - longint'(c.center_y);
        d[2] = longint'(p.z) - longint'(c.center_z);
        h = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        ok = !p.invalid && (h > -(longint'(c.height_margin) * 65536));
        h16 = (h + 32768) >>> 16;
        sq_sum = 0;
        for (int i = 0; i < 3; i++) begin
            e = d[i] - ((h16 * n[i] + 32768) >>> 16);
            a = (e < 0) ? -e : e;
            if (a >= (longint'(1) << 31)) begin
                ok = 1'b0;
                a = 0;
            end
            sq_sum += longint'(a * a);
        end
        r = longint'(c.keep_radius);
        if (!(sq_sum < r * r))
            ok = 1'b0;
        return ok;
    endfunction

    function automatic void apply_reg(input logic [TCPF_CFG_IDX_W-1:0] idx,
                                      input logic [TCPF_CFG_DATA_W-1:0] val);
        case (idx)
            REG_NORMAL_X:      filt_cfg.normal_x = val[TCPF_NORMAL_W-1:0];
            REG_NORMAL_Y:      filt_cfg.normal_y = val[TCPF_NORMAL_W-1:0];
            REG_NORMAL_Z:      filt_cfg.normal_z = val[TCPF_NORMAL_W-1:0];
            REG_CENTER_X:      filt_cfg.center_x = val;
            REG_CENTER_Y:      filt_cfg.center_y = val;
            REG_CENTER_Z:      filt_cfg.center_z = val;
            REG_KEEP_RADIUS:   filt_cfg.keep_radius = val[TCPF_RADIUS_W-1:0];
            REG_HEIGHT_MARGIN: filt_cfg.height_margin = val;
            default: ;
        endcase
    endfunction

    function automatic t_point mk_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                        input logic signed [31:0] z, input logic inv,
                                        input logic [TCPF_INDEX_BITS-1:0] idx);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.invalid = inv;
        p.index = idx;
        return p;
    endfunction

    function automatic void queue_point(input t_point p);
        point_q.insert(point_q.size(), p);
    endfunction

    function automatic logic signed [31:0] jitter(input logic signed [31:0] base,
                                                  input int unsigned spread);
        longint off;
        off = longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        return base + 32'(off);
    endfunction

    // mostly points around the centre, some anywhere in the field range
    function automatic t_point rand_point(input int unsigned spread);
        t_point      p;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            p.x = jitter(filt_cfg.center_x, spread);
            p.y = jitter(filt_cfg.center_y, spread);
            p.z = jitter(filt_cfg.center_z, spread);
        end else begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
            if (kind == 9) begin
                p.x = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                p.z = jitter(filt_cfg.center_z, spread);
            end
        end
        p.invalid = ($urandom_range(0, 9) == 0);
        p.index = TCPF_INDEX_BITS'($urandom);
        return p;
    endfunction

    // driver: one request per accepted point, random gaps between them except in no-idle phases
    always @(posedge i_clk) begin : point_driver
        t_point   cur;
        t_verdict v;
        bit       offer;
        int       src_wait;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && o_s_tready) begin
                v.index = cur.index;
                v.keep = cylinder_hit(filt_cfg, cur);
                verdict_q.insert(verdict_q.size(), v);
                offer = 1'b0;
            end
            if (!offer) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (point_q.size() > 0) begin
                    cur = point_q.pop_front();
                    s_tdata <= {{(PT_W - 3 * TCPF_COORD_W - TCPF_INDEX_BITS){1'b0}},
                                cur.index, cur.z, cur.y, cur.x};
                    s_tuser <= cur.invalid;
                    offer = 1'b1;
                    src_wait = no_idle ? 0 : $urandom_range(0, 12);
                end
            end
            s_tvalid <= offer;
        end
    end

    // monitor: checks each result against the oldest predicted verdict
    always @(posedge i_clk) begin : result_monitor
        t_verdict v;
        bit       rdy;
        int       sink_wait;
        int       long_hold;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_wait = 0;
            long_hold = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_MAX)
                        $display("%0t: unexpected result, index %0d inside %0d", $time,
                                 o_m_tdata[TCPF_INDEX_BITS-1:0], o_m_tuser[0]);
                end else begin
                    v = verdict_q.pop_front();
                    if (o_m_tdata[TCPF_INDEX_BITS-1:0] !== v.index) begin
                        errors++;
                        if (errors <= PRINT_MAX)
                            $display("%0t: kept_index expected %0d actual %0d", $time,
                                     v.index, o_m_tdata[TCPF_INDEX_BITS-1:0]);
                    end
                    if (o_m_tuser[0] !== v.keep) begin
                        errors++;
                        if (errors <= PRINT_MAX)
                            $display("%0t: inside_res of index %0d expected %0d actual %0d",
                                     $time, v.index, v.keep, o_m_tuser[0]);
                    end
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    long_hold = HOLD_LEN;
                sink_wait = no_idle ? 0 : $urandom_range(0, 12);
            end
            if (long_hold > 0) begin
                long_hold--;
                rdy = 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n) begin
            quiet = 0;
        end else begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("[tabletop_cylinder_point_filter_unit] ERROR");
                $finish;
            end
        end
    end

    // leaves the write request high; the caller lowers it after the last one
    task automatic write_reg(input logic [TCPF_CFG_IDX_W-1:0] idx,
                             input logic [TCPF_CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic set_filter(input logic signed [31:0] nx, input logic signed [31:0] ny,
                              input logic signed [31:0] nz, input logic signed [31:0] cx,
                              input logic signed [31:0] cy, input logic signed [31:0] cz,
                              input logic [31:0] rad, input logic signed [31:0] margin);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_KEEP_RADIUS, rad);
        write_reg(REG_HEIGHT_MARGIN, margin);
        // index past the register list is ignored
        write_reg(TCPF_CFG_IDX_W'($urandom_range(REG_HEIGHT_MARGIN + 1, 255)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (point_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_normal();
        return 32'(signed'(18'($urandom)));
    endfunction

    initial begin : stimulus
        logic signed [31:0] nx, ny, nz, cx, cy, cz, margin;
        logic [31:0]        rad;
        int unsigned        spread;
        filt_cfg.normal_x = RST_NORMAL_X;
        filt_cfg.normal_y = RST_NORMAL_Y;
        filt_cfg.normal_z = RST_NORMAL_Z;
        filt_cfg.center_x = RST_CENTER;
        filt_cfg.center_y = RST_CENTER;
        filt_cfg.center_z = RST_CENTER;
        filt_cfg.keep_radius = RST_KEEP_RADIUS;
        filt_cfg.height_margin = RST_HEIGHT_MARGIN;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: upright normal, half metre radius, height just above one centimetre
        queue_point(mk_point(0, 0, 0, 1'b0, 0));
        queue_point(mk_point(0, 0, 656, 1'b0, 1));
        queue_point(mk_point(0, 0, 655, 1'b0, 2));
        queue_point(mk_point(32767, 0, 1000, 1'b0, 3));
        queue_point(mk_point(32768, 0, 1000, 1'b0, 4));
        queue_point(mk_point(0, -32767, 1000, 1'b0, 5));
        queue_point(mk_point(0, -32768, 1000, 1'b0, 6));
        queue_point(mk_point(0, 0, 1000, 1'b1, 7));
        queue_point(mk_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 19'h7FFFF));
        queue_point(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 19'h7FFFF));
        queue_point(mk_point(32'sh80000000, 0, 1000, 1'b0, 19'h55555));
        queue_point(mk_point(32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 1'b0, 19'h2AAAA));
        queue_point(mk_point(0, 0, 32'sh80000000, 1'b0, 12));
        drain();

        // zero radius keeps nothing
        set_filter(0, 0, 65536, 0, 0, 0, 0, 32'sh80000000);
        queue_point(mk_point(0, 0, 1000, 1'b0, 13));
        queue_point(mk_point(0, 0, 0, 1'b0, 14));
        drain();

        // normal at the field extremes, far centre, widest radius
        set_filter(131071, -131072, -65536, 32'sh7FFFFFFF, 32'sh80000000, 0,
                   32'h7FFFFFFF, 32'sh7FFFFFFF);
        queue_point(mk_point(32'sh7FFFFFFF, 32'sh80000000, 0, 1'b0, 15));
        queue_point(mk_point(0, 0, 0, 1'b0, 16));
        queue_point(mk_point(32'sh7FFFF000, 32'sh80001000, 4096, 1'b0, 17));
        drain();
        set_filter(65536, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                   32'h7FFFFFFF, 32'sh80000000);
        queue_point(mk_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 18));
        queue_point(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, 19));
        queue_point(mk_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1, 20));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            no_idle = (ph == 2 || ph == 4);
            case ($urandom_range(0, 5))
                0: begin nx = 0; ny = 0; nz = 65536; end
                1: begin nx = 0; ny = 0; nz = -65536; end
                2: begin nx = 65536; ny = 0; nz = 0; end
                3: begin nx = 46341; ny = 0; nz = 46341; end
                4: begin nx = 37837; ny = -37837; nz = 37837; end
                default: begin nx = rand_normal(); ny = rand_normal(); nz = rand_normal(); end
            endcase
            if (ph == 3) begin
                cx = $urandom;
                cy = $urandom;
                cz = $urandom;
            end else begin
                cx = jitter(0, 1 << 20);
                cy = jitter(0, 1 << 20);
                cz = jitter(0, 1 << 20);
            end
            rad = (32'd1 << $urandom_range(4, 24)) | 32'($urandom_range(0, 15));
            margin = jitter(0, 1 << 16);
            if (ph == 1) begin
                rad = 32'h7FFFFFFF;
                margin = 32'sh7FFFFFFF;
            end
            if (ph == 5)
                margin = 32'sh80000000;
            set_filter(nx, ny, nz, cx, cy, cz, rad, margin);
            spread = (filt_cfg.keep_radius > 31'd8388608) ? (1 << 24) :
                     (filt_cfg.keep_radius < 31'd16) ? 32 : 2 * filt_cfg.keep_radius;
            for (int k = 0; k < 200; k++)
                queue_point(rand_point(spread));
            drain();
        end

        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[tabletop_cylinder_point_filter_unit] OK");
        end else begin
            $display("[tabletop_cylinder_point_filter_unit] ERROR");
        end
        $finish;
    end

endmodule
